>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the dual stack checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, checked in reset as well
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/sdstk_pkg.sv
// ----------------------------------------------------------------------------
// sdstk_pkg
// Types and constants shared by the dual stack controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdstk_pkg;

   // field widths
   localparam int REQ_W    = 3;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int SIZE_W   = 5;

   // default store depth
   localparam int DEPTH_DEFAULT = 16;

   // request codes
   localparam logic [REQ_W-1:0] REQ_PUSH_LOW  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_PUSH_HIGH = 3'd1;
   localparam logic [REQ_W-1:0] REQ_POP_LOW   = 3'd2;
   localparam logic [REQ_W-1:0] REQ_POP_HIGH  = 3'd3;
   localparam logic [REQ_W-1:0] REQ_PEEK_LOW  = 3'd4;
   localparam logic [REQ_W-1:0] REQ_PEEK_HIGH = 3'd5;
   localparam logic [REQ_W-1:0] REQ_QUERY     = 3'd6;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // controller -> datapath commands
   typedef struct packed {
      logic capture;     // latch the request beat
      logic execute;     // update counters / store, issue read
      logic read_done;   // read data is ready for a peek response
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic peek_hit;    // request is a peek on a non-empty stack
   } sts_type;

endpackage

>>> hdl/sdstk_ram.sv
// ----------------------------------------------------------------------------
// sdstk_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdstk_ram #(
   parameter  int WIDTH  = 32,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/sdstk_ctrl.sv
// ----------------------------------------------------------------------------
// sdstk_ctrl
// Sequencer for one request: capture, execute, optional read wait.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdstk_ctrl
   import sdstk_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_READ = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd.capture   = 1'b0;
      cmd.execute   = 1'b0;
      cmd.read_done = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = sts.peek_hit ? ST_READ : ST_IDLE;
         end
         ST_READ: begin
            cmd.read_done = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

>>> hdl/sdstk_dp.sv
// ----------------------------------------------------------------------------
// sdstk_dp
// Dual stack datapath: request latch, stack counters, word store, response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdstk_dp
   import sdstk_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output sts_type                    sts,
   input  logic [REQ_W-1:0]           req_type,
   input  logic signed [WORD_W-1:0]   req_push_value,
   output logic                       rsp_strobe,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic signed [WORD_W-1:0]   rsp_top_value,
   output logic                       rsp_store_full,
   output logic [SIZE_W-1:0]          rsp_low_size,
   output logic [SIZE_W-1:0]          rsp_high_size
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int EXT_W  = CNT_W + SIZE_W;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   // request latch
   logic [REQ_W-1:0]  type_ff;
   logic [WORD_W-1:0] value_ff;

   // stack counters
   logic [CNT_W-1:0] low_ff, low_in;
   logic [CNT_W-1:0] high_ff, high_in;

   // response registers
   logic                strobe_ff, strobe_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [WORD_W-1:0]   top_ff, top_in;
   logic                full_ff, full_in;
   logic [SIZE_W-1:0]   low_size_ff, low_size_in;
   logic [SIZE_W-1:0]   high_size_ff, high_size_in;

   // store ports
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data;

   logic [CNT_W:0]    sum_now, sum_next;
   logic              full_now, low_empty, high_empty;
   logic [CNT_W-1:0]  low_top_idx, high_top_idx, high_push_idx;
   logic [EXT_W-1:0]  low_ext, high_ext;
   logic [STATUS_W-1:0] exec_status;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff  <= req_type;
         value_ff <= req_push_value;
      end
   end

   // occupancy and entry indexes
   assign sum_now       = {1'b0, low_ff} + {1'b0, high_ff};
   assign full_now      = (sum_now >= {1'b0, DEPTH_C});
   assign low_empty     = (low_ff == '0);
   assign high_empty    = (high_ff == '0);
   assign low_top_idx   = low_ff - CNT_W'(1);
   assign high_top_idx  = DEPTH_C - high_ff;
   assign high_push_idx = DEPTH_C - CNT_W'(1) - high_ff;

   assign sts.peek_hit = ((type_ff == REQ_PEEK_LOW)  && !low_empty) ||
                         ((type_ff == REQ_PEEK_HIGH) && !high_empty);

   // request decode: counter updates, store write, status
   always_comb begin
      low_in      = low_ff;
      high_in     = high_ff;
      exec_status = STATUS_OK;
      wr_en       = 1'b0;
      wr_addr     = low_ff[ADDR_W-1:0];
      case (type_ff)
         REQ_PUSH_LOW: begin
            if (full_now) begin
               exec_status = STATUS_FULL;
            end else begin
               wr_en  = cmd.execute;
               low_in = low_ff + CNT_W'(1);
            end
         end
         REQ_PUSH_HIGH: begin
            wr_addr = high_push_idx[ADDR_W-1:0];
            if (full_now) begin
               exec_status = STATUS_FULL;
            end else begin
               wr_en   = cmd.execute;
               high_in = high_ff + CNT_W'(1);
            end
         end
         REQ_POP_LOW: begin
            if (low_empty) begin
               exec_status = STATUS_EMPTY;
            end else begin
               low_in = low_ff - CNT_W'(1);
            end
         end
         REQ_POP_HIGH: begin
            if (high_empty) begin
               exec_status = STATUS_EMPTY;
            end else begin
               high_in = high_ff - CNT_W'(1);
            end
         end
         REQ_PEEK_LOW: begin
            if (low_empty) exec_status = STATUS_EMPTY;
         end
         REQ_PEEK_HIGH: begin
            if (high_empty) exec_status = STATUS_EMPTY;
         end
         default: begin
            // query and the unused code change nothing
         end
      endcase
   end

   assign rd_addr = (type_ff == REQ_PEEK_HIGH) ? high_top_idx[ADDR_W-1:0]
                                               : low_top_idx[ADDR_W-1:0];

   sdstk_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (value_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sizes after this request, masked to the field width
   assign sum_next = {1'b0, low_in} + {1'b0, high_in};
   assign low_ext  = EXT_W'(low_in);
   assign high_ext = EXT_W'(high_in);

   // response beat
   always_comb begin
      strobe_in    = 1'b0;
      status_in    = status_ff;
      top_in       = top_ff;
      full_in      = full_ff;
      low_size_in  = low_size_ff;
      high_size_in = high_size_ff;
      if ((cmd.execute && !sts.peek_hit) || cmd.read_done) begin
         strobe_in    = 1'b1;
         status_in    = cmd.read_done ? STATUS_OK : exec_status;
         top_in       = cmd.read_done ? rd_data : '0;
         full_in      = (sum_next >= {1'b0, DEPTH_C});
         low_size_in  = low_ext[SIZE_W-1:0];
         high_size_in = high_ext[SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff    <= '0;
         high_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         if (cmd.execute) begin
            low_ff  <= low_in;
            high_ff <= high_in;
         end
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      top_ff       <= top_in;
      full_ff      <= full_in;
      low_size_ff  <= low_size_in;
      high_size_ff <= high_size_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_status     = status_ff;
   assign rsp_top_value  = top_ff;
   assign rsp_store_full = full_ff;
   assign rsp_low_size   = low_size_ff;
   assign rsp_high_size  = high_size_ff;

endmodule

>>> hdl/shared_dual_stack.sv
// ----------------------------------------------------------------------------
// shared_dual_stack
// Two stacks sharing one word store: low grows up, high grows down.
// ----------------------------------------------------------------------------
//  Channel   Ports                          Handshake
//  request   req_type, req_push_value       start && !busy
//  response  rsp_status .. rsp_high_size    rsp_strobe, one cycle, no stall
//
//  Push, pop and query: a request goes through ST_EXEC and the registered
//  strobe; a successful peek also goes through ST_READ for the store's
//  registered read. No new request is taken while busy; the next may be
//  accepted at the edge that takes the response.
//  Reset clears both stack counters at once; store contents are not cleared.
//  The receiver cannot stall; every response beat is taken when shown.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shared_dual_stack
   import sdstk_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [REQ_W-1:0]         req_type,
   input  logic signed [WORD_W-1:0] req_push_value,
   output logic                     rsp_strobe,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic signed [WORD_W-1:0] rsp_top_value,
   output logic                     rsp_store_full,
   output logic [SIZE_W-1:0]        rsp_low_size,
   output logic [SIZE_W-1:0]        rsp_high_size
);

   cmd_type cmd;
   sts_type sts;

   sdstk_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   sdstk_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_type       (req_type),
      .req_push_value (req_push_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_status     (rsp_status),
      .rsp_top_value  (rsp_top_value),
      .rsp_store_full (rsp_store_full),
      .rsp_low_size   (rsp_low_size),
      .rsp_high_size  (rsp_high_size)
   );

endmodule

>>> hdl/sdstk_checker.sv
// ----------------------------------------------------------------------------
// sdstk_checker
// Port-level assertions for the dual stack, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sdstk_checker
   import sdstk_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_strobe,
   input logic [STATUS_W-1:0]      rsp_status,
   input logic signed [WORD_W-1:0] rsp_top_value,
   input logic                     rsp_store_full,
   input logic [SIZE_W-1:0]        rsp_low_size,
   input logic [SIZE_W-1:0]        rsp_high_size
);

   // an accepted beat raises busy in the cycle after it
   `ASSERT_CLK(a_accept_busy, clock, reset, (start && !busy) |=> busy, "busy not raised after accept")

   // every beat passes through ST_EXEC before its strobe, so strobes never come back to back
   `ASSERT_CLK(a_strobe_gap, clock, reset, rsp_strobe |=> !rsp_strobe, "back to back response strobes")

   // a full rejection leaves the store full
   `ASSERT_CLK(a_full_flag, clock, reset, (rsp_strobe && (rsp_status == STATUS_FULL)) |-> rsp_store_full, "full rejection without store_full")

   // only a successful peek carries a value
   `ASSERT_CLK(a_top_zero, clock, reset, (rsp_strobe && (rsp_status != STATUS_OK)) |-> (rsp_top_value == 0), "rejected beat with nonzero top value")

   // the two stacks never hold more than the store
   `ASSERT_CLK(a_size_sum, clock, reset, rsp_strobe |-> ((32'(rsp_low_size) + 32'(rsp_high_size)) <= 32'(DEPTH)), "stack sizes exceed depth")

endmodule

bind shared_dual_stack sdstk_checker #(.DEPTH(DEPTH)) u_checker (.*);
